### hdl/slcal_pkg.sv
// Shared types, constants and helper functions for the slab chunk allocator.
package slcal_pkg;

   localparam int MAX_CHUNKS = 4096;
   localparam int IDX_W      = 12;
   localparam int CNT_W      = 13;
   localparam int SIZE_W     = 12;
   localparam int OFS_W      = 16;
   localparam int WORD_W     = 64;
   localparam int BIT_W      = 6;
   localparam int ADDR_W     = IDX_W - BIT_W;
   localparam int DEPTH      = MAX_CHUNKS / WORD_W;
   localparam int PROD_W     = IDX_W + SIZE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT = 2'd1;

   localparam logic [SIZE_W-1:0] RESET_CHUNK_SIZE  = 12'd16;
   localparam logic [CNT_W-1:0]  RESET_CHUNK_COUNT = 13'd4096;

   typedef enum logic {
      ACT_ALLOC,
      ACT_FREE
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_RANGE,
      STATUS_DOUBLE
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_CHK,
      ST_FREE_CHK,
      ST_FREE_CUR,
      ST_CUR_CHK,
      ST_OFFSET,
      ST_RESP
   } state_type;

   typedef struct packed {
      action_type       action;
      logic [IDX_W-1:0] chunk_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] granted_index;
      logic [OFS_W-1:0] byte_offset;
      logic [CNT_W-1:0] free_chunks;
      logic             all_free;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } map_req_type;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] result;
      if (count == '0) begin
         result = CNT_W'(1);
      end else if (count > CNT_W'(MAX_CHUNKS)) begin
         result = CNT_W'(MAX_CHUNKS);
      end else begin
         result = count;
      end
      return result;
   endfunction

   function automatic logic [BIT_W-1:0] find_first(input logic [WORD_W-1:0] vec);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

### hdl/slcal_map_ram.sv
// Used-map memory: one row of chunk marks per word, with per-row valid bits for fast clearing.
module slcal_map_ram
   import slcal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  map_req_type       map_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] map_mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         map_mem[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_word_ff <= map_mem[map_req.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (map_req.clear) begin
         valid_in = '0;
      end else if (map_req.wr_en) begin
         valid_in[map_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (map_req.rd_en) begin
            rd_valid_ff <= valid_ff[map_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

### hdl/slcal_offset.sv
// Byte offset unit: registered index times chunk size, saturated to the 16-bit offset range.
module slcal_offset
   import slcal_pkg::*;
(
   input  logic              clock,
   input  logic [IDX_W-1:0]  index,
   input  logic [SIZE_W-1:0] size,
   output logic [OFS_W-1:0]  offset
);

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(index) * PROD_W'(size);
   end

   assign offset = (|prod_ff[PROD_W-1:OFS_W]) ? '1 : prod_ff[OFS_W-1:0];

endmodule

### hdl/slab_chunk_allocator.sv
// Top level of the slab chunk allocator: request sequencer, map search and result register.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_data
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data
//   csr     | in        | csr_we, csr_index, csr_wdata
//
// An allocate reads 64-chunk map words in a circular search from the cursor (1 to 65 words),
// then passes ST_OFFSET; full or out-of-range requests go straight to ST_RESP, where all end.
// A free passes ST_FREE_CHK, then, unless a double free, ST_FREE_CUR, ST_CUR_CHK and ST_OFFSET.
// Reset and each size or count write in ST_IDLE clear the map at once via per-word valid bits.
// req_stall is high while a transaction is in progress or a configuration write is present.
// A held result lets one more transaction in, which then waits for rsp_stall to fall.
module slab_chunk_allocator
   import slcal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] csize_ff, csize_in;
   logic [CNT_W-1:0]  ccount_ff, ccount_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic              first_ff, first_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   map_req_type       map_req;
   logic [WORD_W-1:0] map_rd;
   logic [OFS_W-1:0]  offset;

   logic [CNT_W-1:0]  n_eff;
   logic [IDX_W-1:0]  n_last;
   logic [IDX_W-1:0]  cur_eff;
   logic [WORD_W-1:0] range_mask;
   logic [WORD_W-1:0] low_mask;
   logic [WORD_W-1:0] cand;
   logic              hit;
   logic [BIT_W-1:0]  hit_bit;
   logic [IDX_W-1:0]  hit_pos;
   logic              req_take;
   logic              rsp_take;
   logic              rsp_room;

   slcal_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (map_rd)
   );

   slcal_offset u_offset (
      .clock  (clock),
      .index  (granted_ff),
      .size   (csize_ff),
      .offset (offset)
   );

   assign n_eff    = eff_count(ccount_ff);
   assign n_last   = IDX_W'(n_eff - CNT_W'(1));
   assign cur_eff  = ({1'b0, cursor_ff} >= n_eff) ? '0 : cursor_ff;

   assign range_mask = (scan_ff == n_last[IDX_W-1:BIT_W])
                       ? ({WORD_W{1'b1}} >> (~n_last[BIT_W-1:0])) : '1;
   assign low_mask   = first_ff ? ({WORD_W{1'b1}} << cursor_ff[BIT_W-1:0]) : '1;
   assign cand       = ~map_rd & range_mask & low_mask;
   assign hit        = |cand;
   assign hit_bit    = find_first(cand);
   assign hit_pos    = {scan_ff, hit_bit};

   assign req_stall = (state_ff != ST_IDLE) || csr_we;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_room  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      csize_in     = csize_ff;
      ccount_in    = ccount_ff;
      cursor_in    = cursor_ff;
      free_in      = free_ff;
      scan_in      = scan_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      map_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we && (csr_index == CSR_CHUNK_SIZE || csr_index == CSR_CHUNK_COUNT)) begin
               map_req.clear = 1'b1;
               cursor_in     = '0;
               if (csr_index == CSR_CHUNK_SIZE) begin
                  csize_in = csr_wdata[SIZE_W-1:0];
                  free_in  = n_eff;
               end else begin
                  ccount_in = csr_wdata[CNT_W-1:0];
                  free_in   = eff_count(csr_wdata[CNT_W-1:0]);
               end
            end else if (req_take) begin
               idx_in    = req_data.chunk_index;
               cursor_in = cur_eff;
               if (req_data.action == ACT_ALLOC) begin
                  granted_in = '0;
                  if (free_ff == '0) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = cur_eff[IDX_W-1:BIT_W];
                     scan_in         = cur_eff[IDX_W-1:BIT_W];
                     first_in        = 1'b1;
                     state_in        = ST_ALLOC_CHK;
                  end
               end else begin
                  granted_in = req_data.chunk_index;
                  if ({1'b0, req_data.chunk_index} >= n_eff) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_RESP;
                  end else begin
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = req_data.chunk_index[IDX_W-1:BIT_W];
                     state_in        = ST_FREE_CHK;
                  end
               end
            end
         end
         ST_ALLOC_CHK: begin
            if (hit) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = scan_ff;
               map_req.wr_data = map_rd | (WORD_W'(1) << hit_bit);
               free_in         = free_ff - CNT_W'(1);
               granted_in      = hit_pos;
               cursor_in       = (hit_pos == n_last) ? '0 : hit_pos + IDX_W'(1);
               status_in       = STATUS_OK;
               state_in        = ST_OFFSET;
            end else begin
               scan_in         = (scan_ff == n_last[IDX_W-1:BIT_W]) ? '0 : scan_ff + ADDR_W'(1);
               first_in        = 1'b0;
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = scan_in;
            end
         end
         ST_FREE_CHK: begin
            if (!map_rd[idx_ff[BIT_W-1:0]]) begin
               status_in = STATUS_DOUBLE;
               state_in  = ST_RESP;
            end else begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = idx_ff[IDX_W-1:BIT_W];
               map_req.wr_data = map_rd & ~(WORD_W'(1) << idx_ff[BIT_W-1:0]);
               free_in         = free_ff + CNT_W'(1);
               status_in       = STATUS_OK;
               state_in        = ST_FREE_CUR;
            end
         end
         ST_FREE_CUR: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = cursor_ff[IDX_W-1:BIT_W];
            state_in        = ST_CUR_CHK;
         end
         ST_CUR_CHK: begin
            if (map_rd[cursor_ff[BIT_W-1:0]]) begin
               cursor_in = idx_ff;
            end
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.granted_index = granted_ff;
               rsp_data_in.byte_offset   = (status_ff == STATUS_OK) ? offset : '0;
               rsp_data_in.free_chunks   = free_ff;
               rsp_data_in.all_free      = (free_ff == n_eff);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csize_ff     <= RESET_CHUNK_SIZE;
         ccount_ff    <= RESET_CHUNK_COUNT;
         cursor_ff    <= '0;
         free_ff      <= eff_count(RESET_CHUNK_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csize_ff     <= csize_in;
         ccount_ff    <= ccount_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      first_ff    <= first_in;
      idx_ff      <= idx_in;
      granted_ff  <= granted_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= n_eff)
      else $error("Free count exceeds the chunk count.");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} < n_eff)
      else $error("Cursor lies outside the slab.");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_CHK && !first_ff && scan_ff == cursor_ff[IDX_W-1:BIT_W]) |-> hit)
      else $error("Allocate search wrapped without finding a free chunk.");

   a_map_write_state: assert property (@(posedge clock) disable iff (reset)
      map_req.wr_en |-> (!map_req.clear && !map_req.rd_en
                         && (state_ff == ST_ALLOC_CHK || state_ff == ST_FREE_CHK)))
      else $error("Map write collides with a clear or a read.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.action == ACT_ALLOC && free_ff == '0)
      |=> (status_ff == STATUS_FULL && state_ff == ST_RESP))
      else $error("Allocate from a full slab not reported as full.");
`endif

endmodule
